// ===== rtl/ief_pkg.sv =====
// ----------------------------------------------------------------------------
// ief_pkg: shared types and constants for the infix expression evaluator
// Character codes, character classes and the control/status bundle of the
// iterative multiply/divide unit.
// ----------------------------------------------------------------------------
package ief_pkg;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [8:0] CH_ZERO  = 9'd48;
    localparam int unsigned RADIX   = 10;

    typedef enum logic [2:0] {
        CC_SPACE,
        CC_DIGIT,
        CC_MULDIV,
        CC_ADDSUB,
        CC_EQ
    } char_class_t;

    // request towards the multiply/divide unit
    typedef struct packed {
        logic start;
        logic is_div;
    } md_ctl_t;

    // status back from the multiply/divide unit
    typedef struct packed {
        logic done;
        logic div_zero;
    } md_sts_t;

    function automatic char_class_t char_class(input logic [7:0] c);
        char_class_t cc;
        case (c)
            CH_SPACE:           cc = CC_SPACE;
            CH_STAR, CH_SLASH:  cc = CC_MULDIV;
            CH_PLUS, CH_MINUS:  cc = CC_ADDSUB;
            CH_EQ:              cc = CC_EQ;
            default:            cc = CC_DIGIT;
        endcase
        return cc;
    endfunction

endpackage

// ===== rtl/ief_muldiv.sv =====
// ----------------------------------------------------------------------------
// ief_muldiv: iterative multiply / signed divide
// One multiplier bit or one quotient bit per cycle. Multiply keeps the low
// W bits; divide truncates toward zero, a zero divisor gives all ones.
// ----------------------------------------------------------------------------
module ief_muldiv #(
    parameter int W = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  ief_pkg::md_ctl_t ctl,
    input  logic [W-1:0]     op_a,
    input  logic [W-1:0]     op_b,
    output ief_pkg::md_sts_t sts,
    output logic [W-1:0]     result
);

    localparam int CW = (W > 1) ? $clog2(W) : 1;

    typedef enum logic [2:0] {
        M_IDLE,
        M_PREP,
        M_RUN,
        M_FIN,
        M_DONE
    } md_state_t;

    md_state_t    state_reg, state_next;
    logic         is_div_reg, is_div_next;
    logic         neg_reg, neg_next;
    logic         dz_reg, dz_next;
    logic [W-1:0] a_reg, a_next;
    logic [W-1:0] b_reg, b_next;
    logic [W-1:0] rem_reg, rem_next;   // remainder, or product accumulator
    logic [W-1:0] quo_reg, quo_next;   // dividend/quotient, or multiplier
    logic [W-1:0] dvs_reg, dvs_next;   // divisor magnitude, or multiplicand
    logic [W-1:0] res_reg, res_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    logic [W:0]   rem_sh;
    logic [W:0]   diff;
    logic [W-1:0] mag_a, mag_b;

    assign rem_sh = {rem_reg, quo_reg[W-1]};
    assign diff   = rem_sh - {1'b0, dvs_reg};
    assign mag_a  = a_reg[W-1] ? (~a_reg + 1'b1) : a_reg;
    assign mag_b  = b_reg[W-1] ? (~b_reg + 1'b1) : b_reg;

    always_comb begin
        state_next  = state_reg;
        is_div_next = is_div_reg;
        neg_next    = neg_reg;
        dz_next     = dz_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        dvs_next    = dvs_reg;
        res_next    = res_reg;
        cnt_next    = cnt_reg;
        case (state_reg)
            M_IDLE: begin
                if (ctl.start) begin
                    is_div_next = ctl.is_div;
                    a_next      = op_a;
                    b_next      = op_b;
                    dz_next     = 1'b0;
                    state_next  = M_PREP;
                end
            end
            M_PREP: begin
                cnt_next = '0;
                rem_next = '0;
                if (is_div_reg) begin
                    if (b_reg == '0) begin
                        res_next   = '1;
                        dz_next    = 1'b1;
                        state_next = M_DONE;
                    end else begin
                        quo_next   = mag_a;
                        dvs_next   = mag_b;
                        neg_next   = a_reg[W-1] ^ b_reg[W-1];
                        state_next = M_RUN;
                    end
                end else begin
                    quo_next   = b_reg;
                    dvs_next   = a_reg;
                    state_next = M_RUN;
                end
            end
            M_RUN: begin
                if (is_div_reg) begin
                    if (!diff[W]) begin
                        rem_next = diff[W-1:0];
                        quo_next = {quo_reg[W-2:0], 1'b1};
                    end else begin
                        rem_next = rem_sh[W-1:0];
                        quo_next = {quo_reg[W-2:0], 1'b0};
                    end
                end else begin
                    if (quo_reg[0]) begin
                        rem_next = rem_reg + dvs_reg;
                    end
                    dvs_next = {dvs_reg[W-2:0], 1'b0};
                    quo_next = {1'b0, quo_reg[W-1:1]};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(W - 1)) begin
                    state_next = M_FIN;
                end
            end
            M_FIN: begin
                if (is_div_reg) begin
                    res_next = neg_reg ? (~quo_reg + 1'b1) : quo_reg;
                end else begin
                    res_next = rem_reg;
                end
                state_next = M_DONE;
            end
            M_DONE: begin
                state_next = M_IDLE;
            end
            default: begin
                state_next = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= M_IDLE;
            dz_reg    <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            dz_reg    <= dz_next;
            cnt_reg   <= cnt_next;
        end
        is_div_reg <= is_div_next;
        neg_reg    <= neg_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        dvs_reg    <= dvs_next;
        res_reg    <= res_next;
    end

    assign sts.done     = (state_reg == M_DONE);
    assign sts.div_zero = dz_reg;
    assign result       = res_reg;

endmodule

// ===== rtl/infix_expression_evaluator.sv =====
// ----------------------------------------------------------------------------
// infix_expression_evaluator: two-level precedence calculator, one character
// per transfer
// ----------------------------------------------------------------------------
// Characters arrive on the s_ stream, one per transfer (s_tdata[7:0]). Spaces
// are skipped, '*' '/' fold the number into the term, '+' '-' fold the term
// into the sum, '=' ends the expression and any other byte is a digit worth
// byte - 48. Arithmetic wraps at VALUE_WIDTH bits.
// On '=' one result leaves on the m_ stream: m_tdata[31:0] is the signed
// value, m_tdata[32] the sticky divide-by-zero flag. The state then clears.
// While a character is in work s_tready is low. A digit scales the number
// by ten and then adds its value; '*' '/' '+' '-' and '=' start a fold through
// the multiply/divide unit, which takes one multiplier or quotient bit per
// cycle, and a zero divisor shortens that fold. After '=' the number is folded
// into the term, the term into the sum, and the sum is then loaded into the
// output register that drives m_tvalid.
// The result sits in an output register; if it has not been taken when the
// next '=' completes its folds, the block waits until m_tready frees it.
// Reset (aresetn low, synchronous) empties the output register and starts a
// fresh expression.
// ----------------------------------------------------------------------------
module infix_expression_evaluator #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] char_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata     // [31:0] result_value, [32] div_zero_error
);

    localparam int W = VALUE_WIDTH;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIGIT,
        S_FOLD_N,
        S_FOLD_T,
        S_OUT
    } state_t;

    state_t                   state_reg, state_next;
    ief_pkg::char_class_t     class_reg, class_next;
    logic [7:0]               char_reg, char_next;
    logic [W-1:0]             sum_reg, sum_next;
    logic [W-1:0]             term_reg, term_next;
    logic [W-1:0]             num_reg, num_next;
    logic                     tdiv_reg, tdiv_next;
    logic                     sub_reg, sub_next;
    logic                     err_reg, err_next;
    logic                     md_start_reg, md_start_next;
    logic                     m_tvalid_reg, m_tvalid_next;
    logic [31:0]              m_res_reg, m_res_next;
    logic                     m_err_reg, m_err_next;

    ief_pkg::md_ctl_t         md_ctl;
    ief_pkg::md_sts_t         md_sts;
    logic [W-1:0]             md_result;

    logic                     s_xfer;
    ief_pkg::char_class_t     in_class;
    logic signed [8:0]        dval;
    logic [W+8:0]             dext;
    logic [W+31:0]            sum_sx;

    assign s_xfer   = s_tvalid && s_tready;
    assign in_class = ief_pkg::char_class(s_tdata);
    assign dval     = $signed({1'b0, char_reg}) - $signed(ief_pkg::CH_ZERO);
    assign dext     = {{W{dval[8]}}, dval};
    assign sum_sx   = {{32{sum_reg[W-1]}}, sum_reg};

    assign md_ctl.start  = md_start_reg;
    assign md_ctl.is_div = tdiv_reg;

    ief_muldiv #(
        .W (W)
    ) u_muldiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (md_ctl),
        .op_a    (term_reg),
        .op_b    (num_reg),
        .sts     (md_sts),
        .result  (md_result)
    );

    always_comb begin
        state_next    = state_reg;
        class_next    = class_reg;
        char_next     = char_reg;
        sum_next      = sum_reg;
        term_next     = term_reg;
        num_next      = num_reg;
        tdiv_next     = tdiv_reg;
        sub_next      = sub_reg;
        err_next      = err_reg;
        md_start_next = 1'b0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_res_next    = m_res_reg;
        m_err_next    = m_err_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_xfer) begin
                    char_next  = s_tdata;
                    class_next = in_class;
                    case (in_class)
                        ief_pkg::CC_SPACE: begin
                            state_next = S_IDLE;
                        end
                        ief_pkg::CC_DIGIT: begin
                            // number * 10 as 8n + 2n; the digit is added next cycle
                            num_next   = {num_reg[W-4:0], 3'b000} + {num_reg[W-2:0], 1'b0};
                            state_next = S_DIGIT;
                        end
                        default: begin
                            md_start_next = 1'b1;
                            state_next    = S_FOLD_N;
                        end
                    endcase
                end
            end
            S_DIGIT: begin
                num_next   = num_reg + dext[W-1:0];
                state_next = S_IDLE;
            end
            S_FOLD_N: begin
                if (md_sts.done) begin
                    term_next = md_result;
                    num_next  = '0;
                    err_next  = err_reg | md_sts.div_zero;
                    if (class_reg == ief_pkg::CC_MULDIV) begin
                        tdiv_next  = (char_reg == ief_pkg::CH_SLASH);
                        state_next = S_IDLE;
                    end else begin
                        state_next = S_FOLD_T;
                    end
                end
            end
            S_FOLD_T: begin
                sum_next  = sub_reg ? (sum_reg - term_reg) : (sum_reg + term_reg);
                term_next = W'(1);
                tdiv_next = 1'b0;
                if (class_reg == ief_pkg::CC_ADDSUB) begin
                    sub_next   = (char_reg == ief_pkg::CH_MINUS);
                    state_next = S_IDLE;
                end else begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_res_next    = sum_sx[31:0];
                    m_err_next    = err_reg;
                    sum_next      = '0;
                    term_next     = W'(1);
                    num_next      = '0;
                    tdiv_next     = 1'b0;
                    sub_next      = 1'b0;
                    err_next      = 1'b0;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            sum_reg      <= '0;
            term_reg     <= W'(1);
            num_reg      <= '0;
            tdiv_reg     <= 1'b0;
            sub_reg      <= 1'b0;
            err_reg      <= 1'b0;
            md_start_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            sum_reg      <= sum_next;
            term_reg     <= term_next;
            num_reg      <= num_next;
            tdiv_reg     <= tdiv_next;
            sub_reg      <= sub_next;
            err_reg      <= err_next;
            md_start_reg <= md_start_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        class_reg <= class_next;
        char_reg  <= char_next;
        m_res_reg <= m_res_next;
        m_err_reg <= m_err_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'b0, m_err_reg, m_res_reg};

    // the arithmetic unit only reports back while a fold is waiting on it
    a_md_done_in_fold: assert property (@(posedge aclk) disable iff (!aresetn)
        md_sts.done |-> (state_reg == S_FOLD_N))
        else $error("multiply/divide completion outside a fold");

    // anything but a space keeps the input stalled on the following cycle
    a_busy_after_char: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tdata != ief_pkg::CH_SPACE)) |=> !s_tready)
        else $error("input accepted while previous character still in work");

    // a new result appears only from the output step
    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == S_OUT))
        else $error("result raised outside the output step");

endmodule
